FILE: sv/srim_pkg.sv
package srim_pkg;

  localparam int unsigned MaxSegsDefault = 64;

  localparam logic [2:0] CMD_CLEAR    = 3'd0;
  localparam logic [2:0] CMD_ADD      = 3'd1;
  localparam logic [2:0] CMD_SUB      = 3'd2;
  localparam logic [2:0] CMD_IDX2CELL = 3'd3;
  localparam logic [2:0] CMD_CELL2IDX = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_TWO_DIM   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } seg_t;

endpackage

FILE: sv/segment_region_index_map_unit.sv
// Segment table with lookups. A new word is taken only in the idle state,
// so each word is accepted, walked and its result registered before the
// next one is taken. The walk reads the stored segments through the table
// memory's single read port, one segment a cycle, each read registered
// before use. The result is then registered. A result that the receiver
// has not taken holds the end of the walk until the output register is free.
// Every command, clear and add included, ends with that walk, which rebuilds
// cell total, orientation and bounding box; subtract writes the trimmed
// segment back during the same walk.
module segment_region_index_map_unit import srim_pkg::*; #(
  parameter int unsigned MAX_SEGS = MaxSegsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] rect_x_i,
  input  logic [15:0] rect_y_i,
  input  logic [15:0] rect_w_i,
  input  logic [15:0] rect_h_i,
  input  logic [21:0] query_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [16:0] cell_x_o,
  output logic [16:0] cell_y_o,
  output logic [21:0] index_out_o,
  output logic [21:0] cell_total_o,
  output logic [6:0]  seg_count_o,
  output logic        is_horizontal_o,
  output logic [16:0] box_left_o,
  output logic [16:0] box_top_o,
  output logic [16:0] box_right_o,
  output logic [16:0] box_bottom_o,
  output logic        box_valid_o
);

  localparam int unsigned IW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int unsigned UW = $clog2(MAX_SEGS + 1);
  localparam int unsigned BW = 17 + IW;
  localparam int unsigned CW = (BW + 1 > 22) ? BW + 1 : 22;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  seg_t mem_q [MAX_SEGS];
  seg_t rd_data_q;
  logic [IW-1:0] pend_idx_q;
  logic pend_q;

  logic [1:0] state_q;
  logic [UW-1:0] used_q, rd_cnt_q;
  logic [2:0] cmd_q, add_status_q;
  logic [15:0] px_q, py_q;
  logic [21:0] q_q;
  logic horiz_q;

  logic found_q, ori_done_q, ori_h_q, bv_q;
  logic [BW-1:0] base_q;
  logic [21:0] sum_w_q, sum_h_q, idx_q;
  logic [16:0] cx_q, cy_q, bl_q, bt_q, br_q, bb_q;

  logic out_valid_q;
  logic [2:0] o_status_q;
  logic [16:0] o_cx_q, o_cy_q, o_bl_q, o_bt_q, o_br_q, o_bb_q;
  logic [21:0] o_idx_q, o_total_q;
  logic [6:0] o_cnt_q;
  logic o_horiz_q, o_bv_q;

  logic accept;
  logic fin_fire;
  logic [2:0] add_status;
  logic add_ok;

  seg_t e, em;
  logic e_empty, em_empty, e_holds;
  logic [15:0] e_len;
  logic [16:0] e_r, e_b, em_r, em_b;
  logic sub_hit, hit3, hit4;
  logic [CW-1:0] sum_cmp;
  logic [15:0] j;
  logic [15:0] off;

  logic wr_en;
  logic [IW-1:0] wr_addr;
  seg_t wr_data;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign fin_fire = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (rect_w_i == 16'd0 || rect_h_i == 16'd0) add_status = ST_EMPTY;
    else if (rect_w_i > 16'd1 && rect_h_i > 16'd1) add_status = ST_TWO_DIM;
    else if (used_q >= UW'(MAX_SEGS)) add_status = ST_FULL;
    else add_status = ST_OK;
  end
  assign add_ok = (add_status == ST_OK);

  always_comb begin
    e = rd_data_q;
    e_empty = (e.w == 16'd0) || (e.h == 16'd0);
    e_len = e_empty ? 16'd0 : ((e.w > 16'd1) ? e.w : e.h);
    e_r = {1'b0, e.x} + {1'b0, e.w} - 17'd1;
    e_b = {1'b0, e.y} + {1'b0, e.h} - 17'd1;
    e_holds = !e_empty && (px_q >= e.x) && ({1'b0, px_q} <= e_r) &&
              (py_q >= e.y) && ({1'b0, py_q} <= e_b);
    sub_hit = pend_q && (cmd_q == CMD_SUB) && !found_q && e_holds;
    sum_cmp = CW'(base_q) + CW'(e_len);
    hit3 = pend_q && (cmd_q == CMD_IDX2CELL) && !found_q && !e_empty &&
           (sum_cmp > CW'(q_q));
    hit4 = pend_q && (cmd_q == CMD_CELL2IDX) && !found_q && e_holds;
    j = 16'(CW'(q_q) - CW'(base_q));
    off = (e.w > 16'd1) ? (px_q - e.x) : (py_q - e.y);
    em = e;
    if (sub_hit) begin
      if (horiz_q) begin
        if (e.x == px_q) begin
          em.x = px_q + 16'd1;
          em.w = e.w - 16'd1;
        end else if (e_r == {1'b0, px_q}) begin
          em.w = e.w - 16'd1;
        end
      end else begin
        if (e.y == py_q) begin
          em.y = py_q + 16'd1;
          em.h = e.h - 16'd1;
        end else if (e_b == {1'b0, py_q}) begin
          em.h = e.h - 16'd1;
        end
      end
    end
    em_empty = (em.w == 16'd0) || (em.h == 16'd0);
    em_r = {1'b0, em.x} + {1'b0, em.w} - 17'd1;
    em_b = {1'b0, em.y} + {1'b0, em.h} - 17'd1;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pend_idx_q;
    wr_data = em;
    if (accept) begin
      wr_en = (cmd_i == CMD_ADD) && add_ok;
      wr_addr = used_q[IW-1:0];
      wr_data = '{x: rect_x_i, y: rect_y_i, w: rect_w_i, h: rect_h_i};
    end else if (sub_hit) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_cnt_q[IW-1:0]];
    pend_idx_q <= rd_cnt_q[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      rd_cnt_q <= '0;
      pend_q <= 1'b0;
      cmd_q <= CMD_CLEAR;
      add_status_q <= ST_OK;
      px_q <= '0;
      py_q <= '0;
      q_q <= '0;
      horiz_q <= 1'b0;
      found_q <= 1'b0;
      ori_done_q <= 1'b0;
      ori_h_q <= 1'b0;
      bv_q <= 1'b0;
      base_q <= '0;
      sum_w_q <= '0;
      sum_h_q <= '0;
      idx_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
      bl_q <= '0;
      bt_q <= '0;
      br_q <= '0;
      bb_q <= '0;
      out_valid_q <= 1'b0;
      o_status_q <= ST_OK;
      o_cx_q <= '0;
      o_cy_q <= '0;
      o_idx_q <= '0;
      o_total_q <= '0;
      o_cnt_q <= '0;
      o_horiz_q <= 1'b0;
      o_bl_q <= '0;
      o_bt_q <= '0;
      o_br_q <= '0;
      o_bb_q <= '0;
      o_bv_q <= 1'b0;
    end else begin
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= cmd_i;
            add_status_q <= add_status;
            px_q <= rect_x_i;
            py_q <= rect_y_i;
            q_q <= query_index_i;
            if (cmd_i == CMD_CLEAR) begin
              used_q <= '0;
            end else if (cmd_i == CMD_ADD && add_ok) begin
              used_q <= used_q + UW'(1);
            end
            rd_cnt_q <= '0;
            pend_q <= 1'b0;
            found_q <= 1'b0;
            ori_done_q <= 1'b0;
            ori_h_q <= 1'b0;
            bv_q <= 1'b0;
            base_q <= '0;
            sum_w_q <= '0;
            sum_h_q <= '0;
            idx_q <= '0;
            cx_q <= '0;
            cy_q <= '0;
            bl_q <= '0;
            bt_q <= '0;
            br_q <= '0;
            bb_q <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (rd_cnt_q < used_q) begin
            rd_cnt_q <= rd_cnt_q + UW'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= S_FIN;
            end
          end
          if (pend_q) begin
            if (sub_hit || hit3 || hit4) begin
              found_q <= 1'b1;
            end else if (!found_q) begin
              base_q <= base_q + BW'(e_len);
            end
            if (hit3) begin
              if (e.w > 16'd1) begin
                cx_q <= {1'b0, e.x} + {1'b0, j};
                cy_q <= {1'b0, e.y};
              end else begin
                cx_q <= {1'b0, e.x};
                cy_q <= {1'b0, e.y} + {1'b0, j};
              end
            end
            if (hit4) begin
              idx_q <= 22'(base_q + BW'(off));
            end
            if (!em_empty) begin
              sum_w_q <= sum_w_q + 22'(em.w);
              sum_h_q <= sum_h_q + 22'(em.h);
              if (!ori_done_q) begin
                if (em.w > 16'd1) begin
                  ori_done_q <= 1'b1;
                  ori_h_q <= 1'b1;
                end else if (em.h > 16'd1) begin
                  ori_done_q <= 1'b1;
                  ori_h_q <= 1'b0;
                end
              end
              bv_q <= 1'b1;
              if (!bv_q || {1'b0, em.x} < bl_q) bl_q <= {1'b0, em.x};
              if (!bv_q || {1'b0, em.y} < bt_q) bt_q <= {1'b0, em.y};
              if (!bv_q || em_r > br_q) br_q <= em_r;
              if (!bv_q || em_b > bb_q) bb_q <= em_b;
            end
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            case (cmd_q)
              CMD_ADD: o_status_q <= add_status_q;
              CMD_SUB, CMD_IDX2CELL, CMD_CELL2IDX:
                o_status_q <= found_q ? ST_OK : ST_NOT_FOUND;
              default: o_status_q <= ST_OK;
            endcase
            o_cx_q <= cx_q;
            o_cy_q <= cy_q;
            o_idx_q <= idx_q;
            o_total_q <= ori_h_q ? sum_w_q : sum_h_q;
            o_cnt_q <= 7'(used_q);
            o_horiz_q <= ori_h_q;
            horiz_q <= ori_h_q;
            o_bv_q <= bv_q;
            o_bl_q <= bv_q ? bl_q : 17'd0;
            o_bt_q <= bv_q ? bt_q : 17'd0;
            o_br_q <= bv_q ? br_q : 17'd0;
            o_bb_q <= bv_q ? bb_q : 17'd0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = o_status_q;
  assign cell_x_o = o_cx_q;
  assign cell_y_o = o_cy_q;
  assign index_out_o = o_idx_q;
  assign cell_total_o = o_total_q;
  assign seg_count_o = o_cnt_q;
  assign is_horizontal_o = o_horiz_q;
  assign box_left_o = o_bl_q;
  assign box_top_o = o_bt_q;
  assign box_right_o = o_br_q;
  assign box_bottom_o = o_bb_q;
  assign box_valid_o = o_bv_q;

endmodule
